// ===== hw/rtl/mcth_pkg.sv =====
package mcth_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEFAULT  = 2048;
    localparam int COUNT_BITS_DEFAULT = 24;

    // Frame geometry
    localparam int MAX_HEIGHT         = 4096;
    localparam int ROW_BITS           = 12;
    localparam int MIN_FRAME_DIM      = 3;
    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;

    // Configuration port
    localparam int CFG_ADDR_BITS   = 1;
    localparam int CFG_DATA_BITS   = 13;
    localparam int CFG_WIDTH_BITS  = 12;
    localparam int CFG_HEIGHT_BITS = 13;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Stream widths
    localparam int S_DATA_BITS = 40;
    localparam int M_DATA_BITS = 40;

    // Pixel and code widths
    localparam int PIX_BITS       = 8;
    localparam int WSUM_BITS      = 18;
    localparam int WIN_SUM_BITS   = 12;
    localparam int CODE_BITS      = 9;
    localparam int HIST_BINS      = 512;
    localparam int OUT_COUNT_BITS = 24;
    localparam int WIN_TAPS       = 9;

    // Gray conversion: (299R + 587G + 114B) / 1000, divide done as a
    // multiply by a rounded-up reciprocal, exact for sums up to 255000
    localparam int GRAY_R_WEIGHT  = 299;
    localparam int GRAY_G_WEIGHT  = 587;
    localparam int GRAY_B_WEIGHT  = 114;
    localparam int GRAY_RECIP     = 268436;
    localparam int GRAY_SHIFT     = 28;
    localparam int GRAY_PROD_BITS = 37;

    // Output queue
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    typedef enum logic {
        OP_PIXEL    = 1'b0,
        OP_READ_BIN = 1'b1
    } opcode_t;

    typedef enum logic {
        KIND_CENSUS    = 1'b0,
        KIND_BIN_COUNT = 1'b1
    } result_kind_t;

    // Request into the histogram: a census code to count or a bin to read
    typedef struct packed {
        logic                 valid;
        opcode_t              opcode;
        logic [CODE_BITS-1:0] addr;
        logic                 frame_last;
    } hist_req_t;

    typedef struct packed {
        result_kind_t              kind;
        logic [CODE_BITS-1:0]      census_code;
        logic [OUT_COUNT_BITS-1:0] bin_count;
        logic                      frame_last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t result;
    } hist_rsp_t;

endpackage

// ===== hw/rtl/mcth_hist.sv =====
module mcth_hist
    import mcth_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  hist_req_t req,
    output hist_rsp_t rsp,
    output logic      busy
);

    localparam int BIN_BITS = CODE_BITS;

    logic [COUNT_BITS-1:0] hist_mem [HIST_BINS];
    logic [COUNT_BITS-1:0] rdata_reg;
    hist_req_t             reqb_reg;

    logic                  clr_busy_reg;
    logic [BIN_BITS-1:0]   clr_addr_reg;

    logic                  fwd_valid_reg;
    logic [BIN_BITS-1:0]   fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic [COUNT_BITS-1:0]     old_cnt;
    logic [COUNT_BITS-1:0]     new_cnt;
    logic [OUT_COUNT_BITS-1:0] old_sat;
    logic                      wr_en;
    logic [BIN_BITS-1:0]       wr_addr;
    logic [COUNT_BITS-1:0]     wr_data;

    // Sweep all bins to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == BIN_BITS'(HIST_BINS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign busy = clr_busy_reg;

    // Register the request beside the memory read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reqb_reg <= '0;
        end
        else
        begin
            reqb_reg <= req;
        end
    end

    // Take the write of the previous transaction, the memory read missed it
    assign old_cnt = (fwd_valid_reg && (fwd_addr_reg == reqb_reg.addr)) ? fwd_data_reg
                                                                         : rdata_reg;

    // Count up with saturation, or clear on a bin read
    always_comb
    begin
        if (reqb_reg.opcode == OP_READ_BIN)
        begin
            new_cnt = '0;
        end
        else if (&old_cnt)
        begin
            new_cnt = old_cnt;
        end
        else
        begin
            new_cnt = old_cnt + COUNT_BITS'(1);
        end
    end

    assign wr_en   = clr_busy_reg | reqb_reg.valid;
    assign wr_addr = clr_busy_reg ? clr_addr_reg : reqb_reg.addr;
    assign wr_data = clr_busy_reg ? '0 : new_cnt;

    // Histogram memory, one read and one write port
    always_ff @(posedge clk)
    begin
        rdata_reg <= hist_mem[req.addr];
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last write for the bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= reqb_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= reqb_reg.addr;
        fwd_data_reg <= new_cnt;
    end

    // Clamp the reported count to the output width
    generate
        if (COUNT_BITS > OUT_COUNT_BITS)
        begin : g_sat
            assign old_sat = (|old_cnt[COUNT_BITS-1:OUT_COUNT_BITS]) ? '1
                                                                   : old_cnt[OUT_COUNT_BITS-1:0];
        end
        else
        begin : g_ext
            assign old_sat = OUT_COUNT_BITS'(old_cnt);
        end
    endgenerate

    // Build the result
    always_comb
    begin
        rsp.valid = reqb_reg.valid;
        if (reqb_reg.opcode == OP_READ_BIN)
        begin
            rsp.result.kind        = KIND_BIN_COUNT;
            rsp.result.census_code = '0;
            rsp.result.bin_count   = old_sat;
            rsp.result.frame_last  = 1'b0;
        end
        else
        begin
            rsp.result.kind        = KIND_CENSUS;
            rsp.result.census_code = reqb_reg.addr;
            rsp.result.bin_count   = '0;
            rsp.result.frame_last  = reqb_reg.frame_last;
        end
    end

`ifndef SYNTH
    a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !req.valid)
        else $error("histogram transaction during clearing pass");

    a_clear_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clr_busy_reg) |-> ($past(clr_addr_reg) == BIN_BITS'(HIST_BINS - 1)))
        else $error("clearing pass ended before the last bin");
`endif

endmodule

// ===== hw/rtl/mcth_out_fifo.sv =====
module mcth_out_fifo
    import mcth_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push_valid,
    input  result_t                  push_data,
    output logic                     pop_valid,
    output result_t                  pop_data,
    input  logic                     pop_ready,
    output logic [FIFO_CNT_BITS-1:0] count
);

    result_t                  fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_CNT_BITS-1:0] count_reg;
    logic                     pop_fire;

    assign pop_valid = (count_reg != '0);
    assign pop_fire  = pop_valid & pop_ready;
    assign pop_data  = fifo_mem[rd_ptr_reg];
    assign count     = count_reg;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_valid && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push_valid && pop_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !pop_fire) |-> (count_reg != FIFO_CNT_BITS'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_empty_pointers: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("result queue empty with pointers apart");
`endif

endmodule

// ===== hw/rtl/modified_census_transform_histogram_unit.sv =====
// A census code or bin count reaches the master side through the result queue.
// Throughput: one transaction per cycle while s_axis_tready is high, set by the 6-stage
// pipeline (gray multiply, line store read, window, sum, compare, histogram
// read-modify-write). s_axis_tready drops when the 16-entry result queue plus items in
// flight would fill. Reset: control state clears at once; the histogram then clears its
// 512 bins, one bin per cycle, with s_axis_tready low. Configuration writes are taken always.
module modified_census_transform_histogram_unit
    import mcth_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [S_DATA_BITS-1:0]   s_axis_tdata,   // red[7:0], green[15:8], blue[23:16],
                                                     // bin_index[32:24], zero pad
    input  logic [0:0]               s_axis_tuser,   // opcode[0]
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [M_DATA_BITS-1:0]   m_axis_tdata,   // census_code[8:0], bin_count[32:9],
                                                     // zero pad
    output logic [0:0]               m_axis_tuser,   // result_kind[0]
    output logic                     m_axis_tlast,
    input  logic                     cfg_wen,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int RST_WIDTH  = (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;
    localparam int LINE_BITS  = 2 * PIX_BITS;

    // Configuration and frame position
    logic [COL_BITS-1:0]        width_m1_reg;
    logic [ROW_BITS-1:0]        height_m1_reg;
    logic [COL_BITS-1:0]        cfg_width_m1;
    logic [ROW_BITS-1:0]        cfg_height_m1;
    logic [CFG_WIDTH_BITS-1:0]  cfg_w;
    logic [CFG_HEIGHT_BITS-1:0] cfg_h;
    logic [COL_BITS-1:0]        col_reg;
    logic [COL_BITS-1:0]        col_next;
    logic [ROW_BITS-1:0]        row_reg;
    logic [ROW_BITS-1:0]        row_next;

    // Input decode
    logic                 in_accept;
    opcode_t              in_opcode;
    logic                 in_emit;
    logic                 in_last;

    // Stage 1
    logic                 v1_reg;
    opcode_t              op1_reg;
    logic [PIX_BITS-1:0]  red1_reg;
    logic [PIX_BITS-1:0]  green1_reg;
    logic [PIX_BITS-1:0]  blue1_reg;
    logic [CODE_BITS-1:0] bin1_reg;
    logic [COL_BITS-1:0]  col1_reg;
    logic                 emit1_reg;
    logic                 last1_reg;
    logic [WSUM_BITS-1:0] wsum1;

    // Stage 2
    logic                      v2_reg;
    opcode_t                   op2_reg;
    logic [CODE_BITS-1:0]      bin2_reg;
    logic [COL_BITS-1:0]       col2_reg;
    logic                      emit2_reg;
    logic                      last2_reg;
    logic [WSUM_BITS-1:0]      wsum2_reg;
    logic [LINE_BITS-1:0]      ls_rdata_reg;
    logic [GRAY_PROD_BITS-1:0] gray_prod;
    logic [PIX_BITS-1:0]       gray2;
    logic                      pix2;
    logic [LINE_BITS-1:0]      line_mem [MAX_WIDTH];
    logic [PIX_BITS-1:0]       window_reg [WIN_TAPS];

    // Stage 3
    logic                    v3_reg;
    opcode_t                 op3_reg;
    logic [CODE_BITS-1:0]    bin3_reg;
    logic                    emit3_reg;
    logic                    last3_reg;
    logic [WIN_SUM_BITS-1:0] row_sum [3];
    logic [WIN_SUM_BITS-1:0] win_sum3;

    // Stage 4
    logic                    v4_reg;
    opcode_t                 op4_reg;
    logic [CODE_BITS-1:0]    bin4_reg;
    logic                    emit4_reg;
    logic                    last4_reg;
    logic [WIN_SUM_BITS-1:0] sum4_reg;
    logic [PIX_BITS-1:0]     win4_reg [WIN_TAPS];
    logic [CODE_BITS-1:0]    code4;

    // Stage 5 and histogram
    logic                 v5_reg;
    opcode_t              op5_reg;
    logic [CODE_BITS-1:0] bin5_reg;
    logic                 emit5_reg;
    logic                 last5_reg;
    logic [CODE_BITS-1:0] code5_reg;
    hist_req_t            hist_req;
    hist_rsp_t            hist_rsp;
    logic                 hist_busy;

    // Output queue
    result_t                  out_data;
    logic [FIFO_CNT_BITS-1:0] fifo_count;
    logic [2:0]               pipe_cnt;

    // Clamp configuration writes to the supported frame size
    assign cfg_w = cfg_wdata[CFG_WIDTH_BITS-1:0];
    assign cfg_h = cfg_wdata[CFG_HEIGHT_BITS-1:0];

    always_comb
    begin
        if (cfg_w < CFG_WIDTH_BITS'(MIN_FRAME_DIM))
        begin
            cfg_width_m1 = COL_BITS'(MIN_FRAME_DIM - 1);
        end
        else if (32'(cfg_w) > 32'(MAX_WIDTH))
        begin
            cfg_width_m1 = COL_BITS'(MAX_WIDTH - 1);
        end
        else
        begin
            cfg_width_m1 = COL_BITS'(cfg_w - CFG_WIDTH_BITS'(1));
        end

        if (cfg_h < CFG_HEIGHT_BITS'(MIN_FRAME_DIM))
        begin
            cfg_height_m1 = ROW_BITS'(MIN_FRAME_DIM - 1);
        end
        else if (cfg_h > CFG_HEIGHT_BITS'(MAX_HEIGHT))
        begin
            cfg_height_m1 = ROW_BITS'(MAX_HEIGHT - 1);
        end
        else
        begin
            cfg_height_m1 = ROW_BITS'(cfg_h - CFG_HEIGHT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_m1_reg  <= COL_BITS'(RST_WIDTH - 1);
            height_m1_reg <= ROW_BITS'(FRAME_HEIGHT_RESET - 1);
        end
        else if (cfg_wen)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:  width_m1_reg  <= cfg_width_m1;
                REG_FRAME_HEIGHT: height_m1_reg <= cfg_height_m1;
                default:          ;
            endcase
        end
    end

    // Input transaction
    assign pipe_cnt = 3'(v1_reg) + 3'(v2_reg) + 3'(v3_reg) + 3'(v4_reg) + 3'(v5_reg)
                    + 3'(hist_rsp.valid);
    assign s_axis_tready = !hist_busy
                         && ((32'(fifo_count) + 32'(pipe_cnt)) < 32'(FIFO_DEPTH));
    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign in_opcode = opcode_t'(s_axis_tuser[0]);
    assign in_emit   = (row_reg >= ROW_BITS'(2)) && (col_reg >= COL_BITS'(2));
    assign in_last   = (row_reg == height_m1_reg) && (col_reg == width_m1_reg);

    // Advance the raster position; any register write restarts the frame
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_wen)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_accept && (in_opcode == OP_PIXEL))
        begin
            if (col_reg == width_m1_reg)
            begin
                col_next = '0;
                row_next = (row_reg == height_m1_reg) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage 1: weighted color sum
    assign wsum1 = WSUM_BITS'(red1_reg)   * WSUM_BITS'(GRAY_R_WEIGHT)
                 + WSUM_BITS'(green1_reg) * WSUM_BITS'(GRAY_G_WEIGHT)
                 + WSUM_BITS'(blue1_reg)  * WSUM_BITS'(GRAY_B_WEIGHT);

    always_ff @(posedge clk)
    begin
        op1_reg    <= in_opcode;
        red1_reg   <= s_axis_tdata[7:0];
        green1_reg <= s_axis_tdata[15:8];
        blue1_reg  <= s_axis_tdata[23:16];
        bin1_reg   <= s_axis_tdata[32:24];
        col1_reg   <= col_reg;
        emit1_reg  <= in_emit;
        last1_reg  <= in_last;

        op2_reg    <= op1_reg;
        bin2_reg   <= bin1_reg;
        col2_reg   <= col1_reg;
        emit2_reg  <= emit1_reg;
        last2_reg  <= last1_reg;
        wsum2_reg  <= wsum1;
    end

    // Stage 2: gray value, line store update, window shift
    assign gray_prod = GRAY_PROD_BITS'(wsum2_reg) * GRAY_PROD_BITS'(GRAY_RECIP);
    assign gray2     = gray_prod[GRAY_SHIFT +: PIX_BITS];
    assign pix2      = v2_reg && (op2_reg == OP_PIXEL);

    // Line store: upper byte two rows up, lower byte one row up
    always_ff @(posedge clk)
    begin
        ls_rdata_reg <= line_mem[col1_reg];
        if (pix2)
        begin
            line_mem[col2_reg] <= {ls_rdata_reg[PIX_BITS-1:0], gray2};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_TAPS; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else if (pix2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                window_reg[k * 3]     <= window_reg[k * 3 + 1];
                window_reg[k * 3 + 1] <= window_reg[k * 3 + 2];
            end
            window_reg[2] <= ls_rdata_reg[LINE_BITS-1:PIX_BITS];
            window_reg[5] <= ls_rdata_reg[PIX_BITS-1:0];
            window_reg[8] <= gray2;
        end
    end

    // Stage 3: window sum
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            row_sum[k] = WIN_SUM_BITS'(window_reg[k * 3]) + WIN_SUM_BITS'(window_reg[k * 3 + 1])
                       + WIN_SUM_BITS'(window_reg[k * 3 + 2]);
        end
        win_sum3 = row_sum[0] + row_sum[1] + row_sum[2];
    end

    always_ff @(posedge clk)
    begin
        op3_reg   <= op2_reg;
        bin3_reg  <= bin2_reg;
        emit3_reg <= emit2_reg;
        last3_reg <= last2_reg;

        op4_reg   <= op3_reg;
        bin4_reg  <= bin3_reg;
        emit4_reg <= emit3_reg;
        last4_reg <= last3_reg;
        sum4_reg  <= win_sum3;
        for (int i = 0; i < WIN_TAPS; i++)
        begin
            win4_reg[i] <= window_reg[i];
        end

        op5_reg   <= op4_reg;
        bin5_reg  <= bin4_reg;
        emit5_reg <= emit4_reg;
        last5_reg <= last4_reg;
        code5_reg <= code4;
    end

    // Stage 4: compare each tap times nine against the sum
    always_comb
    begin
        for (int k = 0; k < WIN_TAPS; k++)
        begin
            code4[CODE_BITS - 1 - k] = (WIN_SUM_BITS'(win4_reg[k]) * WIN_SUM_BITS'(WIN_TAPS))
                                       >= sum4_reg;
        end
    end

    // Stage 5: send codes of interior pixels and bin reads to the histogram
    always_comb
    begin
        hist_req.valid      = v5_reg && ((op5_reg == OP_READ_BIN) || emit5_reg);
        hist_req.opcode     = op5_reg;
        hist_req.addr       = (op5_reg == OP_READ_BIN) ? bin5_reg : code5_reg;
        hist_req.frame_last = last5_reg;
    end

    mcth_hist #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hist_req),
        .rsp   (hist_rsp),
        .busy  (hist_busy)
    );

    mcth_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (hist_rsp.valid),
        .push_data  (hist_rsp.result),
        .pop_valid  (m_axis_tvalid),
        .pop_data   (out_data),
        .pop_ready  (m_axis_tready),
        .count      (fifo_count)
    );

    // Master-side packing
    assign m_axis_tdata = {(M_DATA_BITS - CODE_BITS - OUT_COUNT_BITS)'(0),
                           out_data.bin_count, out_data.census_code};
    assign m_axis_tuser = out_data.kind;
    assign m_axis_tlast = out_data.frame_last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb
    import mcth_pkg::*;
;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 12;
    localparam int RANDOM_ITEMS     = 850;

    // Census and histogram predictor with the queue of results still owed
    class census_tracker;
        localparam int unsigned BIN_MAX = (1 << COUNT_BITS_DEFAULT) - 1;
        localparam int unsigned OUT_MAX = (1 << OUT_COUNT_BITS) - 1;

        logic [CFG_WIDTH_BITS-1:0]  width_reg;
        logic [CFG_HEIGHT_BITS-1:0] height_reg;
        logic [PIX_BITS-1:0]        line_store [2*MAX_WIDTH_DEFAULT];
        logic [PIX_BITS-1:0]        window [WIN_TAPS];
        int unsigned                col;
        int unsigned                row;
        int unsigned                code_counts [HIST_BINS];
        logic [CODE_BITS-1:0]       last_code;
        result_t                    pending_results [$];
        int                         errors;

        function new();
            width_reg  = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            foreach (line_store[i]) line_store[i] = '0;
            foreach (window[i]) window[i] = '0;
            foreach (code_counts[i]) code_counts[i] = 0;
            col       = 0;
            row       = 0;
            last_code = '0;
            errors    = 0;
        endfunction

        // Any register write restarts the frame; the histogram stays
        function void configure(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_FRAME_WIDTH:  width_reg = value[CFG_WIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: height_reg = value[CFG_HEIGHT_BITS-1:0];
                default: ;
            endcase
            col = 0;
            row = 0;
        endfunction

        function void take_item(opcode_t op, logic [7:0] red, logic [7:0] green,
                                logic [7:0] blue, logic [CODE_BITS-1:0] bin);
            result_t     res;
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            int unsigned gray;
            int unsigned top;
            int unsigned mid;
            int unsigned sum;
            bit          emit;
            bit          last;
            logic [CODE_BITS-1:0] code;

            // Bin read: report the saturated count, then clear the bin
            if (op == OP_READ_BIN) begin
                res.kind        = KIND_BIN_COUNT;
                res.census_code = '0;
                res.bin_count   = (code_counts[bin] > OUT_MAX) ? OUT_MAX : code_counts[bin];
                res.frame_last  = 1'b0;
                code_counts[bin] = 0;
                pending_results.push_back(res);
                return;
            end

            // Clamp the frame geometry
            w = width_reg;
            if (w < MIN_FRAME_DIM) w = MIN_FRAME_DIM;
            if (w > MAX_WIDTH_DEFAULT) w = MAX_WIDTH_DEFAULT;
            h = height_reg;
            if (h < MIN_FRAME_DIM) h = MIN_FRAME_DIM;
            if (h > MAX_HEIGHT) h = MAX_HEIGHT;
            c = (col >= w) ? w - 1 : col;
            r = (row >= h) ? h - 1 : row;

            gray = (GRAY_R_WEIGHT * red + GRAY_G_WEIGHT * green + GRAY_B_WEIGHT * blue) / 1000;

            // Shift the two stored rows of this column
            top = line_store[2*c];
            mid = line_store[2*c + 1];
            line_store[2*c]     = mid[7:0];
            line_store[2*c + 1] = gray[7:0];

            // Shift the window left and load the new column
            for (int k = 0; k < 3; k++) begin
                window[3*k]     = window[3*k + 1];
                window[3*k + 1] = window[3*k + 2];
            end
            window[2] = top[7:0];
            window[5] = mid[7:0];
            window[8] = gray[7:0];

            emit = (r >= 2) && (c >= 2);
            last = (r == h - 1) && (c == w - 1);

            // Advance the raster position
            if (c + 1 >= w) begin
                col = 0;
                row = (r + 1 >= h) ? 0 : r + 1;
            end else begin
                col = c + 1;
                row = r;
            end

            if (!emit) return;

            sum = 0;
            foreach (window[k]) sum += window[k];
            code = '0;
            foreach (window[k]) if (9 * window[k] >= sum) code[CODE_BITS-1-k] = 1'b1;

            if (code_counts[code] < BIN_MAX) code_counts[code]++;
            last_code = code;

            res.kind        = KIND_CENSUS;
            res.census_code = code;
            res.bin_count   = '0;
            res.frame_last  = last;
            pending_results.push_back(res);
        endfunction

        function void check_output(result_t got);
            result_t want;

            if (pending_results.size() == 0) begin
                $error("result with nothing pending: kind %0d code %0d count %0d last %0d",
                       got.kind, got.census_code, got.bin_count, got.frame_last);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind) begin
                $error("result_kind mismatch: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.census_code !== want.census_code) begin
                $error("census_code mismatch: expected %0d, actual %0d",
                       want.census_code, got.census_code);
                errors++;
            end
            if (got.bin_count !== want.bin_count) begin
                $error("bin_count mismatch: expected %0d, actual %0d",
                       want.bin_count, got.bin_count);
                errors++;
            end
            if (got.frame_last !== want.frame_last) begin
                $error("frame_last mismatch: expected %0d, actual %0d",
                       want.frame_last, got.frame_last);
                errors++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [S_DATA_BITS-1:0]   s_axis_tdata = '0;   // red[7:0], green[15:8], blue[23:16],
                                                   // bin_index[32:24], zero pad
    logic [0:0]               s_axis_tuser = '0;   // opcode[0]
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_DATA_BITS-1:0]   m_axis_tdata;        // census_code[8:0], bin_count[32:9],
                                                   // zero pad
    logic [0:0]               m_axis_tuser;        // result_kind[0]
    logic                     m_axis_tlast;
    logic                     cfg_wen = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    census_tracker tracker = new();
    result_t       got;
    int            idle_cycles = 0;
    int            src_calm = 0;
    bit            sink_hold_req = 1'b0;
    logic [7:0]    pal_lo = '0;
    logic [7:0]    pal_hi = '0;

    modified_census_transform_histogram_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Offer one transaction and hold it until the block takes it
    task automatic send_item(input opcode_t op, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue,
                             input logic [CODE_BITS-1:0] bin);
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {7'b0, bin, blue, green, red};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        tracker.take_item(op, red, green, blue, bin);
    endtask

    task automatic send_pixel(input bit flat);
        logic [7:0] v;
        if (flat) begin
            v = $urandom_range(0, 1) ? pal_lo : pal_hi;
            send_item(OP_PIXEL, v, v, v, 9'($urandom));
        end else begin
            send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom));
        end
    endtask

    // Read a bin that was likely hit, or any bin
    task automatic send_read();
        send_item(OP_READ_BIN, 8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom_range(0, 1) ? tracker.last_code : 9'($urandom));
    endtask

    task automatic idle_source(input int cycles);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Insert a random gap before the next transaction: mostly none or short
    task automatic sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (src_calm > 0) begin
            src_calm--;
            return;
        end
        if (pick < 3) src_calm = $urandom_range(20, 150);
        else if (pick < 6) idle_source($urandom_range(10, 40));
        else if (pick < 30) idle_source($urandom_range(1, 3));
    endtask

    // Stop offering and wait until every pending result is back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (tracker.pending_results.size() != 0) @(negedge clk);
    endtask

    // Drain, then let border pixels still in the pipeline finish
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen = 1'b0;
        tracker.configure(idx, value);
    endtask

    // Receiver: random stalls, calm stretches, and one long hold on request
    initial begin : sink_driver
        int pick;
        int calm;
        calm = 0;
        forever begin
            @(negedge clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(negedge clk);
            end else if (calm > 0) begin
                calm--;
                m_axis_tready = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    calm = $urandom_range(20, 200);
                    m_axis_tready = 1'b1;
                end else if (pick < 6) begin
                    m_axis_tready = 1'b0;
                    repeat ($urandom_range(8, 40) - 1) @(negedge clk);
                end else if (pick < 30) begin
                    m_axis_tready = 1'b0;
                    repeat ($urandom_range(1, 3) - 1) @(negedge clk);
                end else begin
                    m_axis_tready = 1'b1;
                end
            end
        end
    end

    // Check each accepted result transaction
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind        = result_kind_t'(m_axis_tuser[0]);
            got.census_code = m_axis_tdata[CODE_BITS-1:0];
            got.bin_count   = m_axis_tdata[CODE_BITS +: OUT_COUNT_BITS];
            got.frame_last  = m_axis_tlast;
            tracker.check_output(got);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL modified_census_transform_histogram_unit");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned              span;
        int unsigned              pick;
        int unsigned              random_sent;
        int unsigned              phase_no;
        bit                       flat;
        logic [CFG_DATA_BITS-1:0] w_val;
        logic [CFG_DATA_BITS-1:0] h_val;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset geometry: first codes of row 2 in a 640-wide frame
        send_item(OP_READ_BIN, 8'h00, 8'h00, 8'h00, 9'd0);
        for (int i = 0; i < 2 * FRAME_WIDTH_RESET + 5; i++) begin
            sender_gap();
            send_pixel(1'b0);
        end

        // Directed: 3x3 frames with extreme pixels, reads of edge bins
        settle();
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 3);
        send_item(OP_READ_BIN, 8'hFF, 8'hFF, 8'hFF, 9'd0);
        send_item(OP_READ_BIN, 8'h00, 8'h00, 8'h00, 9'h1FF);
        send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00, 9'h1FF);
        send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 9'h000);
        send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00, 9'h1FF);
        send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 9'h000);
        send_item(OP_PIXEL, 8'hFF, 8'h00, 8'h00, 9'h1FF);
        send_item(OP_PIXEL, 8'h00, 8'hFF, 8'h00, 9'h000);
        send_item(OP_PIXEL, 8'h00, 8'h00, 8'hFF, 9'h1FF);
        send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 9'h000);
        send_item(OP_PIXEL, 8'h00, 8'h00, 8'h00, 9'h1FF);
        send_item(OP_READ_BIN, 8'h00, 8'h00, 8'h00, tracker.last_code);
        // Flat frame gives all ones; a read mid-frame must not disturb it
        for (int i = 0; i < 9; i++) begin
            send_item(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 9'($urandom));
            if (i == 4) send_item(OP_READ_BIN, 8'h00, 8'h00, 8'h00, 9'h1FF);
        end
        send_item(OP_READ_BIN, 8'h00, 8'h00, 8'h00, 9'h1FF);

        // Random phases, mostly small frames, some clamped geometry
        random_sent = 0;
        phase_no    = 0;
        while (random_sent < RANDOM_ITEMS) begin
            settle();
            pick = $urandom_range(0, 99);
            if (phase_no == 0 || pick < 10) w_val = $urandom_range(0, 2);
            else if (pick < 16) w_val = $urandom_range(MAX_WIDTH_DEFAULT, 4095);
            else w_val = $urandom_range(3, 9);
            pick = $urandom_range(0, 99);
            if (phase_no == 0 || pick < 10) h_val = $urandom_range(0, 2);
            else if (pick < 16) h_val = $urandom_range(MAX_HEIGHT, 8191);
            else h_val = $urandom_range(3, 6);
            pick = $urandom_range(0, 3);
            if (phase_no == 0 || pick != 0) write_reg(REG_FRAME_WIDTH, w_val);
            if (phase_no == 0 || pick != 1) write_reg(REG_FRAME_HEIGHT, h_val);

            span   = $urandom_range(10, 60);
            flat   = ($urandom_range(0, 3) == 0);
            pal_lo = 8'($urandom);
            pal_hi = $urandom_range(0, 1) ? pal_lo + 8'd1 : 8'($urandom);
            for (int i = 0; i < span; i++) begin
                sender_gap();
                if ($urandom_range(0, 99) < 15) send_read();
                else send_pixel(flat);
                if (i == span / 2 && $urandom_range(0, 3) == 0) drain_results();
            end
            random_sent += span;
            phase_no++;
        end

        // Widest line, clamped: hold the receiver off while pixels keep coming
        settle();
        write_reg(REG_FRAME_WIDTH, 4095);
        write_reg(REG_FRAME_HEIGHT, 3);
        sink_hold_req = 1'b1;
        for (int i = 0; i < 2 * MAX_WIDTH_DEFAULT + 8; i++) begin
            if (i >= 400) sender_gap();
            send_pixel(1'b0);
        end

        // Tallest frame, clamped: run through the frame end and wrap
        settle();
        write_reg(REG_FRAME_WIDTH, 3);
        write_reg(REG_FRAME_HEIGHT, 8191);
        pal_lo = 8'h40;
        pal_hi = 8'h41;
        for (int i = 0; i < 3 * MAX_HEIGHT + 9; i++) begin
            sender_gap();
            if (i % 1000 == 500) send_read();
            send_pixel(i[9]);
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("PASS modified_census_transform_histogram_unit");
        else
            $display("FAIL modified_census_transform_histogram_unit");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/mcth_pkg.sv
hw/rtl/mcth_hist.sv
hw/rtl/mcth_out_fifo.sv
hw/rtl/modified_census_transform_histogram_unit.sv
tb/tb.sv
